### rtl/core/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// CSV field splitter package
// Beat types, configuration layout and byte constants shared by the splitter
// core and its top level.
// ----------------------------------------------------------------------------
`default_nettype none

package csvfs_pkg;

  // Width of the configuration write data: the widest register.
  localparam int unsigned CfgDataW = 9;

  // Largest value the field limit register can hold.
  localparam int unsigned MaxFieldsRegMax = (2 ** CfgDataW) - 1;

  // Register indexes on the configuration port.
  typedef enum logic [0:0] {
    CFG_DELIMITER  = 1'b0,
    CFG_MAX_FIELDS = 1'b1
  } cfg_index_e;

  // Reset values of the configuration registers.
  localparam logic [7:0]          DelimiterReset = 8'd44;
  localparam logic [CfgDataW-1:0] MaxFieldsReset = 9'd256;

  // Byte codes with fixed meaning in the text stream.
  localparam logic [7:0] QuoteByte   = 8'h22;
  localparam logic [7:0] NewlineByte = 8'h0A;

  // One input beat: a text byte or an end-of-data mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_marker;
  } in_beat_t;

  // One result beat: the descriptor of a finished field.
  typedef struct packed {
    logic [7:0]  field_index;
    logic [31:0] field_offset;
    logic [31:0] field_length;
    logic        needs_unescape;
    logic        last_in_record;
  } out_beat_t;

  // Configuration as seen by the splitter core.
  typedef struct packed {
    logic [7:0]          delimiter;
    logic [CfgDataW-1:0] fld_limit;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/csvfs_parser.sv
// ----------------------------------------------------------------------------
// CSV field splitter core
// Holds the tokenizer state and works out, in one pass of logic per accepted
// beat, the next state and the descriptor of a field that ends on that beat.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_parser #(
  parameter int unsigned MAX_FIELDS  = 256,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  input  wire csvfs_pkg::in_beat_t item_i,
  input  wire csvfs_pkg::cfg_t    cfg_i,
  output logic                    res_valid_o,
  output csvfs_pkg::out_beat_t    res_o
);

  // The field count never passes the smaller of the register range and MAX_FIELDS.
  localparam int unsigned LimCap =
    (MAX_FIELDS < csvfs_pkg::MaxFieldsRegMax) ? MAX_FIELDS : csvfs_pkg::MaxFieldsRegMax;
  localparam int unsigned CntW = $clog2(LimCap + 1);
  localparam int unsigned CmpW = 13;

  logic                   quoted_q, quoted_d;
  logic                   closed_q, closed_d;
  logic                   escape_q, escape_d;
  logic                   open_q, open_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  logic [CntW-1:0]        limit;
  logic                   skipping;
  logic                   reaches_limit;
  logic [OFFSET_BITS-1:0] pos_next;
  logic [OFFSET_BITS-1:0] length;
  logic                   emit;
  logic                   emit_last;

  // Effective field limit and whether the rest of the record is skipped.
  always_comb begin
    if (CmpW'(cfg_i.fld_limit) < CmpW'(MAX_FIELDS)) begin
      limit = CntW'(cfg_i.fld_limit);
    end else begin
      limit = CntW'(MAX_FIELDS);
    end
    skipping      = cnt_q >= limit;
    reaches_limit = ((CntW + 1)'(cnt_q) + 1'b1) >= (CntW + 1)'(limit);
  end

  // The stream position stops at its top value.
  assign pos_next = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign length   = pos_q - start_q;

  // Next state and field end detection for the beat on the input.
  always_comb begin
    quoted_d  = quoted_q;
    closed_d  = closed_q;
    escape_d  = escape_q;
    open_d    = open_q;
    pos_d     = pos_q;
    start_d   = start_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    emit_last = 1'b0;

    if (item_i.end_marker) begin
      // End of data closes an open record and reports its open field.
      if (open_q) begin
        emit      = !skipping;
        emit_last = 1'b1;
        quoted_d  = 1'b0;
        closed_d  = 1'b0;
        escape_d  = 1'b0;
        cnt_d     = '0;
        open_d    = 1'b0;
      end
    end else begin
      pos_d  = pos_next;
      open_d = 1'b1;
      if (item_i.data_byte == csvfs_pkg::QuoteByte) begin
        // A quote straight after a closing quote is an escape.
        if (closed_q) begin
          quoted_d = 1'b1;
          escape_d = 1'b1;
          closed_d = 1'b0;
        end else if (quoted_q) begin
          quoted_d = 1'b0;
          closed_d = 1'b1;
        end else begin
          quoted_d = 1'b1;
        end
      end else begin
        closed_d = 1'b0;
        if (item_i.data_byte == cfg_i.delimiter && !quoted_q) begin
          // Delimiter ends the field; the record carries on.
          if (!skipping) begin
            emit      = 1'b1;
            emit_last = reaches_limit;
            cnt_d     = cnt_q + 1'b1;
          end
          start_d  = pos_next;
          escape_d = 1'b0;
        end else if (item_i.data_byte == csvfs_pkg::NewlineByte && !quoted_q) begin
          // Newline ends the field and the record.
          emit      = !skipping;
          emit_last = 1'b1;
          start_d   = pos_next;
          quoted_d  = 1'b0;
          escape_d  = 1'b0;
          cnt_d     = '0;
          open_d    = 1'b0;
        end
      end
    end
  end

  // Descriptor of the field that ends on this beat.
  always_comb begin
    res_valid_o          = item_valid_i && emit;
    res_o.field_index    = 8'(cnt_q);
    res_o.field_offset   = 32'(start_q);
    res_o.field_length   = 32'(length);
    res_o.needs_unescape = escape_q;
    res_o.last_in_record = emit_last;
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q <= 1'b0;
      closed_q <= 1'b0;
      escape_q <= 1'b0;
      open_q   <= 1'b0;
      pos_q    <= '0;
      start_q  <= '0;
      cnt_q    <= '0;
    end else if (item_valid_i) begin
      quoted_q <= quoted_d;
      closed_q <= closed_d;
      escape_q <= escape_d;
      open_q   <= open_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      cnt_q    <= cnt_d;
    end
  end

  // A closing quote is never seen while still inside quotes.
  assert property (@(posedge clk_i) disable iff (!rst_ni) closed_q |-> !quoted_q)
    else $error("closing quote flag set while quoted");

  // End of data leaves no record and no quoted state behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && item_i.end_marker) |=> (!open_q && !quoted_q && cnt_q == '0))
    else $error("record state not cleared by end of data");

  // A field that is not the last of its record moves the field count on by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last_in_record) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("field count did not advance after a field");

  // The field start never lies beyond the stream position.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_q <= pos_q)
    else $error("field start beyond stream position");

endmodule

`default_nettype wire

### rtl/core/csv_field_splitter_unit.sv
// ----------------------------------------------------------------------------
// CSV field splitter
// Streaming CSV tokenizer: takes one text byte per beat and gives one
// descriptor per field, with a registered result stage and a skid stage.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                   Payload
//   in       input      in_valid_i / in_stall_o     in_data_i  (csvfs_pkg::in_beat_t)
//   out      output     out_valid_o / out_stall_i   out_data_o (csvfs_pkg::out_beat_t)
//   cfg      input      cfg_we_i                    cfg_index_i, cfg_wdata_i
//
// One input beat is taken every cycle while in_stall_o is low; a field descriptor
// leaves from the result register, or through the skid stage while the output stalls.
// The tokenizer state updates once per accepted beat.
// in_stall_o rises only while the skid stage holds a result that the stalled
// output could not take; it comes straight from a register.
// Reset clears the tokenizer state and both result stages, and returns the
// configuration to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_splitter_unit #(
  parameter int unsigned MAX_FIELDS  = 256,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire csvfs_pkg::in_beat_t             in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output csvfs_pkg::out_beat_t                 out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [0:0]                      cfg_index_i,
  input  wire logic [csvfs_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  csvfs_pkg::cfg_t      cfg_q;
  logic                 in_accept;
  logic                 res_valid;
  csvfs_pkg::out_beat_t res;

  logic                 out_valid_q, out_valid_d;
  csvfs_pkg::out_beat_t out_data_q, out_data_d;
  logic                 skid_valid_q, skid_valid_d;
  csvfs_pkg::out_beat_t skid_data_q, skid_data_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter <= csvfs_pkg::DelimiterReset;
      cfg_q.fld_limit <= csvfs_pkg::MaxFieldsReset;
    end else if (cfg_we_i) begin
      case (csvfs_pkg::cfg_index_e'(cfg_index_i))
        csvfs_pkg::CFG_DELIMITER:  cfg_q.delimiter <= cfg_wdata_i[7:0];
        csvfs_pkg::CFG_MAX_FIELDS: cfg_q.fld_limit <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  csvfs_parser #(
    .MAX_FIELDS  (MAX_FIELDS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_accept),
    .item_i       (in_data_i),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result register with a skid stage behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid;
        out_data_d  = res;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The skid stage only fills behind a full result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid stage full while result register empty");

  // A beat in the skid stage moves to the output as soon as the output drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q &&
                                        out_data_q == $past(skid_data_q)))
    else $error("skid beat not forwarded");

endmodule

`default_nettype wire
